// ===== rtl/core/bsc_pkg.sv =====
// Shared types, codes and character decode for the bracket syntax checker.
package bsc_pkg;

	// Input beat: one character with its line marks
	typedef struct packed {
		logic [7:0] char_code;
		logic       has_char;
		logic       line_end;
	} in_beat_t;

	// Result beat: one per line
	typedef struct packed {
		logic [2:0]  line_status;
		logic [14:0] corrupt_score;
		logic [63:0] completion_score;
	} out_beat_t;

	// Line status codes; a line fault is held with the same codes
	localparam logic [2:0] ST_BALANCED   = 3'd0;
	localparam logic [2:0] ST_CORRUPTED  = 3'd1;
	localparam logic [2:0] ST_INCOMPLETE = 3'd2;
	localparam logic [2:0] ST_UNMATCHED  = 3'd3;
	localparam logic [2:0] ST_OVERFLOW   = 3'd4;
	localparam logic [2:0] FAULT_NONE    = 3'd0;

	// Bracket kind codes: ( [ { <
	localparam logic [1:0] BR_ROUND  = 2'd0;
	localparam logic [1:0] BR_SQUARE = 2'd1;
	localparam logic [1:0] BR_CURLY  = 2'd2;
	localparam logic [1:0] BR_ANGLE  = 2'd3;

	typedef struct packed {
		logic       is_open;
		logic       is_close;
		logic [1:0] kind;
	} char_class_t;

	// Decode one ASCII character into opener / closer and bracket kind
	function automatic char_class_t classify(input logic [7:0] ch);
		char_class_t c;
		c = '{is_open: 1'b0, is_close: 1'b0, kind: BR_ROUND};
		unique case (ch)
			8'h28: c = '{is_open: 1'b1, is_close: 1'b0, kind: BR_ROUND};
			8'h5B: c = '{is_open: 1'b1, is_close: 1'b0, kind: BR_SQUARE};
			8'h7B: c = '{is_open: 1'b1, is_close: 1'b0, kind: BR_CURLY};
			8'h3C: c = '{is_open: 1'b1, is_close: 1'b0, kind: BR_ANGLE};
			8'h29: c = '{is_open: 1'b0, is_close: 1'b1, kind: BR_ROUND};
			8'h5D: c = '{is_open: 1'b0, is_close: 1'b1, kind: BR_SQUARE};
			8'h7D: c = '{is_open: 1'b0, is_close: 1'b1, kind: BR_CURLY};
			8'h3E: c = '{is_open: 1'b0, is_close: 1'b1, kind: BR_ANGLE};
			default: c = '{is_open: 1'b0, is_close: 1'b0, kind: BR_ROUND};
		endcase
		return c;
	endfunction

	// Score of a wrong closer, by the kind of the closer that was found
	function automatic logic [14:0] closer_score(input logic [1:0] kind);
		logic [14:0] s;
		unique case (kind)
			BR_ROUND:  s = 15'd3;
			BR_SQUARE: s = 15'd57;
			BR_CURLY:  s = 15'd1197;
			BR_ANGLE:  s = 15'd25137;
			default:   s = 15'd0;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/bracket_syntax_checker.sv =====
// Bracket syntax checker: line-by-line bracket balance check with a stack in memory.
//
// Input channel char_valid / char_stall / char_beat carries one character per beat
// with has_char and line_end marks. Output channel res_valid / res_stall / res_beat
// carries one status beat per line, on the beat that closes it.
// Steps per input beat:
//   - ignored character, opener, fault or a closer that empties the stack: accept only.
//   - matching closer leaving a non-empty stack, not ending the line: accept, then a
//     refill step in which the new top of stack is read back from the stack memory.
//   - line end, balanced or faulted: accept, report.
//   - line end, incomplete with open brackets: accept, walk, report; the walk reads the
//     stack through the single read port, one entry per cycle, multiply-by-5 and add.
// The result appears in the output register on the cycle after the report step.
// The output register is held while res_stall is high; input beats without a line
// end keep flowing meanwhile, a line end waits in the report step until the
// register is free.
// Reset clears depth, fault and handshake state at once; the stack memory is not
// cleared, as only entries below the depth are ever read. No clearing pass.
module bracket_syntax_checker #(
	parameter int STACK_DEPTH = 128
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  bsc_pkg::in_beat_t char_beat,
	output logic              res_valid,
	input  logic              res_stall,
	output bsc_pkg::out_beat_t res_beat
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_REFILL,
		S_WALK,
		S_REPORT
	} state_t;

	state_t               state_q;
	logic [DW-1:0]        depth_q;
	logic [2:0]           fault_q;
	logic [14:0]          fscore_q;
	logic [1:0]           top_q;
	logic [DW-1:0]        widx_q;
	logic                 rd_vld_q;
	logic [2:0]           status_q;
	logic [14:0]          err_q;
	logic [63:0]          comp_q;
	logic                 res_valid_q;
	bsc_pkg::out_beat_t   res_beat_q;

	bsc_pkg::char_class_t cls;
	logic                 accept;
	logic                 take;
	logic                 push;
	logic                 pop;
	logic [DW-1:0]        depth_nx;
	logic [2:0]           fault_nx;
	logic [14:0]          fscore_nx;
	logic                 out_free;
	logic [DW-1:0]        rd_idx;
	logic [AW-1:0]        rd_addr;
	logic [1:0]           rd_data;
	logic [63:0]          comp_step;

	assign char_stall = (state_q != S_IDLE);
	assign accept     = char_valid && !char_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign res_valid  = res_valid_q;
	assign res_beat   = res_beat_q;

	// character step: push, pop or fault
	always_comb begin
		cls       = bsc_pkg::classify(char_beat.char_code);
		take      = char_beat.has_char && (fault_q == bsc_pkg::FAULT_NONE);
		push      = 1'b0;
		pop       = 1'b0;
		fault_nx  = fault_q;
		fscore_nx = fscore_q;
		if (take) begin
			if (cls.is_open) begin
				if (depth_q == DEPTH_FULL) begin
					fault_nx = bsc_pkg::ST_OVERFLOW;
				end else begin
					push = 1'b1;
				end
			end else if (cls.is_close) begin
				if (depth_q == '0) begin
					fault_nx = bsc_pkg::ST_UNMATCHED;
				end else if (top_q != cls.kind) begin
					fault_nx  = bsc_pkg::ST_CORRUPTED;
					fscore_nx = bsc_pkg::closer_score(cls.kind);
				end else begin
					pop = 1'b1;
				end
			end
		end
		depth_nx = depth_q;
		if (push) begin
			depth_nx = depth_q + DW'(1);
		end else if (pop) begin
			depth_nx = depth_q - DW'(1);
		end
	end

	// read address: walk index while walking, else the entry under the top
	always_comb begin
		if (state_q == S_WALK) begin
			rd_idx = widx_q - DW'(1);
		end else begin
			rd_idx = depth_q - DW'(2);
		end
		rd_addr = rd_idx[AW-1:0];
	end

	// one walk step: score * 5 + kind + 1
	assign comp_step = {comp_q[61:0], 2'b00} + comp_q + {62'd0, rd_data} + 64'd1;

	bsc_stack_mem #(
		.DEPTH (STACK_DEPTH),
		.AW    (AW)
	) u_stack (
		.clk     (clk),
		.wr_en   (accept && push),
		.wr_addr (depth_q[AW-1:0]),
		.wr_data (cls.kind),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// control, stack state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			fault_q     <= bsc_pkg::FAULT_NONE;
			fscore_q    <= '0;
			top_q       <= bsc_pkg::BR_ROUND;
			widx_q      <= '0;
			rd_vld_q    <= 1'b0;
			status_q    <= bsc_pkg::ST_BALANCED;
			err_q       <= '0;
			comp_q      <= '0;
			res_valid_q <= 1'b0;
			res_beat_q  <= '0;
		end else begin
			// output valid: set by the report step, dropped once the beat is taken
			if (state_q == S_REPORT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (char_beat.line_end) begin
							depth_q  <= '0;
							fault_q  <= bsc_pkg::FAULT_NONE;
							fscore_q <= '0;
							comp_q   <= '0;
							err_q    <= (fault_nx == bsc_pkg::ST_CORRUPTED) ?
								fscore_nx : 15'd0;
							if (fault_nx != bsc_pkg::FAULT_NONE) begin
								status_q <= fault_nx;
								state_q  <= S_REPORT;
							end else if (depth_nx == '0) begin
								status_q <= bsc_pkg::ST_BALANCED;
								state_q  <= S_REPORT;
							end else begin
								status_q <= bsc_pkg::ST_INCOMPLETE;
								widx_q   <= depth_nx;
								rd_vld_q <= 1'b0;
								state_q  <= S_WALK;
							end
						end else begin
							depth_q  <= depth_nx;
							fault_q  <= fault_nx;
							fscore_q <= fscore_nx;
							if (push) begin
								top_q <= cls.kind;
							end
							if (pop && depth_nx != '0) begin
								state_q <= S_REFILL;
							end
						end
					end
				end
				S_REFILL: begin
					top_q   <= rd_data;
					state_q <= S_IDLE;
				end
				S_WALK: begin
					if (rd_vld_q) begin
						comp_q <= comp_step;
					end
					if (widx_q != '0) begin
						widx_q   <= widx_q - DW'(1);
						rd_vld_q <= 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						state_q  <= S_REPORT;
					end
				end
				S_REPORT: begin
					if (out_free) begin
						res_beat_q <= '{line_status: status_q, corrupt_score: err_q,
							completion_score: comp_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// the stack never holds more than its depth
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DEPTH_FULL)
		else $error("stack depth beyond capacity");

	// a top refill only follows an accepted pop
	a_refill_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REFILL |-> $past(accept) && $past(pop))
		else $error("refill without a pop");

	// a result beat is only loaded from the report step
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_REPORT))
		else $error("result raised outside report step");

	// a report with a free output register is loaded into it next cycle
	a_report_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_REPORT && out_free |=> res_valid_q && state_q == S_IDLE)
		else $error("report not loaded");

	// a corrupted line always carries a non-zero score
	a_corrupt_score: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q == bsc_pkg::ST_CORRUPTED |-> fscore_q != '0)
		else $error("corrupted line without score");

endmodule

// ===== rtl/core/bsc_stack_mem.sv =====
// Open-bracket stack memory: one write port, one registered read port.
module bsc_stack_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data
);

	logic [1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the bracket syntax checker: directed lines, full-stack lines and random traffic.
`timescale 1ns / 100ps

module tb_top;

	localparam int DEPTH      = 128;
	localparam int ITEMS_EACH = 300;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_WAIT = 2 * DEPTH + 16;
	localparam int GEN_SLOTS  = DEPTH + 8;

	logic               clk;
	logic               arst_n;
	logic               char_valid;
	logic               char_stall;
	bsc_pkg::in_beat_t  char_beat;
	logic               res_valid;
	logic               res_stall = 1'b0;
	bsc_pkg::out_beat_t res_beat;

	// Line predictor state
	logic [1:0]          open_kinds [DEPTH];
	int                  open_count = 0;
	logic [2:0]          open_fault = bsc_pkg::FAULT_NONE;
	logic [14:0]         fault_pts  = '0;
	bsc_pkg::out_beat_t  line_reports [$];

	// Traffic shaping and tallies
	int    idle_pct     = 0;
	int    stall_pct    = 0;
	int    beats_sent   = 0;
	int    reports_seen = 0;
	int    errors       = 0;
	int    quiet_cycles = 0;
	int    status_seen [5] = '{0, 0, 0, 0, 0};
	string openers      = "([{<";
	string closers      = ")]}>";

	bracket_syntax_checker #(.STACK_DEPTH(DEPTH)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_beat   (res_beat)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bsc_pkg::in_beat_t pack_char(input logic [7:0] ch, input logic has,
			input logic last);
		bsc_pkg::in_beat_t b;
		b.char_code = ch;
		b.has_char  = has;
		b.line_end  = last;
		return b;
	endfunction

	// Update the line state with one accepted beat; queue the report on a line end
	function automatic void track_beat(input bsc_pkg::in_beat_t b);
		logic               opener;
		logic               closer;
		logic [1:0]         kind;
		logic [63:0]        walk;
		bsc_pkg::out_beat_t rep;
		opener = 1'b0;
		closer = 1'b0;
		kind   = bsc_pkg::BR_ROUND;
		case (b.char_code)
			"(": begin opener = 1'b1; kind = bsc_pkg::BR_ROUND;  end
			"[": begin opener = 1'b1; kind = bsc_pkg::BR_SQUARE; end
			"{": begin opener = 1'b1; kind = bsc_pkg::BR_CURLY;  end
			"<": begin opener = 1'b1; kind = bsc_pkg::BR_ANGLE;  end
			")": begin closer = 1'b1; kind = bsc_pkg::BR_ROUND;  end
			"]": begin closer = 1'b1; kind = bsc_pkg::BR_SQUARE; end
			"}": begin closer = 1'b1; kind = bsc_pkg::BR_CURLY;  end
			">": begin closer = 1'b1; kind = bsc_pkg::BR_ANGLE;  end
			default: ;
		endcase
		// characters after a fault are dropped until the line ends
		if (b.has_char && open_fault == bsc_pkg::FAULT_NONE) begin
			if (opener) begin
				if (open_count >= DEPTH) begin
					open_fault = bsc_pkg::ST_OVERFLOW;
				end else begin
					open_kinds[open_count] = kind;
					open_count++;
				end
			end else if (closer) begin
				if (open_count == 0) begin
					open_fault = bsc_pkg::ST_UNMATCHED;
				end else if (open_kinds[open_count - 1] != kind) begin
					open_fault = bsc_pkg::ST_CORRUPTED;
					case (kind)
						bsc_pkg::BR_ROUND:  fault_pts = 15'd3;
						bsc_pkg::BR_SQUARE: fault_pts = 15'd57;
						bsc_pkg::BR_CURLY:  fault_pts = 15'd1197;
						default:            fault_pts = 15'd25137;
					endcase
				end else begin
					open_count--;
				end
			end
		end
		if (b.line_end) begin
			rep = '0;
			if (open_fault != bsc_pkg::FAULT_NONE) begin
				rep.line_status = open_fault;
				if (open_fault == bsc_pkg::ST_CORRUPTED)
					rep.corrupt_score = fault_pts;
			end else if (open_count == 0) begin
				rep.line_status = bsc_pkg::ST_BALANCED;
			end else begin
				// top of stack first, base 5, wraps at 64 bits
				rep.line_status = bsc_pkg::ST_INCOMPLETE;
				walk = '0;
				for (int i = open_count - 1; i >= 0; i--)
					walk = walk * 64'd5 + {62'd0, open_kinds[i]} + 64'd1;
				rep.completion_score = walk;
			end
			line_reports = {line_reports, rep};
			open_count = 0;
			open_fault = bsc_pkg::FAULT_NONE;
			fault_pts  = '0;
		end
	endfunction

	// Present one beat at the falling edge, hold it until taken
	task automatic send_beat(input bsc_pkg::in_beat_t b);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_beat  <= b;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		track_beat(b);
		beats_sent++;
	endtask

	task automatic send_text(input string s, input bit ends_line);
		for (int i = 0; i < s.len(); i++)
			send_beat(pack_char(s[i], 1'b1, ends_line && i == s.len() - 1));
	endtask

	// One line built from a bracket walk with random noise, mostly well formed
	task automatic send_random_line();
		logic [1:0]        gen_stack [GEN_SLOTS];
		int                gen_top;
		bsc_pkg::in_beat_t line [$];
		int                len;
		int                pick;
		int                push_pct;
		bit                noisy;
		logic [1:0]        k;
		gen_top  = 0;
		noisy    = ($urandom_range(99) < 30);
		push_pct = 45;
		len      = $urandom_range(0, 24);
		if ($urandom_range(24) == 0) begin
			// deep line that runs up to the stack limit
			push_pct = 97;
			len      = $urandom_range(DEPTH - 4, DEPTH + 6);
		end
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			k    = 2'($urandom_range(3));
			if (pick < push_pct) begin
				line = {line, pack_char(openers[k], 1'b1, 1'b0)};
				gen_stack[gen_top] = k;
				gen_top++;
			end else if (pick < 80) begin
				// matching closer, or a stray one on an empty stack
				if (gen_top > 0) begin
					gen_top--;
					k = gen_stack[gen_top];
				end
				line = {line, pack_char(closers[k], 1'b1, 1'b0)};
			end else if (pick < 86 && noisy) begin
				line = {line, pack_char(closers[k], 1'b1, 1'b0)};
			end else if (pick < 94) begin
				line = {line, pack_char(8'($urandom_range(255)), 1'b1, 1'b0)};
			end else begin
				line = {line, pack_char(8'($urandom_range(255)), 1'b0, 1'b0)};
			end
		end
		if ($urandom_range(99) < 55) begin
			while (gen_top > 0) begin
				gen_top--;
				line = {line, pack_char(closers[gen_stack[gen_top]], 1'b1, 1'b0)};
			end
		end
		// end mark on the last character, or on a beat of its own
		if (line.size() > 0 && $urandom_range(1) == 1)
			line[line.size() - 1].line_end = 1'b1;
		else
			line = {line, pack_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1)};
		foreach (line[i])
			send_beat(line[i]);
	endtask

	task automatic test_directed_lines();
		idle_pct  = 0;
		stall_pct = 0;
		send_beat(pack_char("x", 1'b0, 1'b1));
		// all four openers left open; ignored beats in between
		send_text("([{<", 1'b0);
		send_beat(pack_char(">", 1'b0, 1'b0));
		send_beat(pack_char("a", 1'b1, 1'b1));
		send_text(")", 1'b1);
		// wrong closer, then an opener on the end beat that must be dropped
		send_text("[>", 1'b0);
		send_beat(pack_char("(", 1'b1, 1'b1));
		send_text("([)", 1'b1);
		send_text("(}", 1'b1);
		send_text("<]", 1'b1);
		send_text("{}", 1'b1);
		send_beat(pack_char(8'h00, 1'b1, 1'b0));
		send_beat(pack_char(8'hFF, 1'b1, 1'b1));
	endtask

	task automatic test_full_stack();
		idle_pct  = 0;
		stall_pct = 0;
		// exactly full: incomplete, score wraps
		for (int i = 0; i < DEPTH; i++)
			send_beat(pack_char(openers[$urandom_range(3)], 1'b1, 1'b0));
		send_beat(pack_char("z", 1'b0, 1'b1));
		// one opener past full: overflow
		for (int i = 0; i <= DEPTH; i++)
			send_beat(pack_char(openers[$urandom_range(3)], 1'b1, i == DEPTH));
	endtask

	task automatic test_random_lines(input int idle, input int stall);
		int start;
		idle_pct  = idle;
		stall_pct = stall;
		start     = beats_sent;
		while (beats_sent - start < ITEMS_EACH)
			send_random_line();
	endtask

	// Receiver back-pressure
	always @(negedge clk)
		res_stall <= ($urandom_range(99) < stall_pct);

	// Compare each report beat with the oldest prediction
	always @(posedge clk) begin : check_report
		bsc_pkg::out_beat_t want;
		if (arst_n && res_valid && !res_stall) begin
			reports_seen++;
			if (line_reports.size() == 0) begin
				$display("%0t: report with none expected, got %p", $time, res_beat);
				errors++;
			end else begin
				want = line_reports.pop_front();
				status_seen[want.line_status]++;
				if (res_beat.line_status !== want.line_status) begin
					$display("%0t: line_status expected %0d, got %0d", $time,
						want.line_status, res_beat.line_status);
					errors++;
				end
				if (res_beat.corrupt_score !== want.corrupt_score) begin
					$display("%0t: corrupt_score expected %0d, got %0d", $time,
						want.corrupt_score, res_beat.corrupt_score);
					errors++;
				end
				if (res_beat.completion_score !== want.completion_score) begin
					$display("%0t: completion_score expected %0d, got %0d", $time,
						want.completion_score, res_beat.completion_score);
					errors++;
				end
			end
		end
	end

	// Watchdog: no beat on either channel for too long
	always @(posedge clk) begin
		if (!arst_n || (char_valid && !char_stall) || (res_valid && !res_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == IDLE_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
			$display("[bracket_syntax_checker] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n     = 1'b0;
		char_valid = 1'b0;
		char_beat  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_lines();
		test_full_stack();
		test_random_lines(0, 0);
		test_random_lines(53, 0);
		test_random_lines(0, 53);
		test_random_lines(32, 32);
		@(negedge clk);
		char_valid <= 1'b0;

		// drain outstanding reports, then watch for strays
		while (line_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d characters; %0d line reports: %0d balanced, %0d corrupted,",
			beats_sent, reports_seen, status_seen[bsc_pkg::ST_BALANCED],
			status_seen[bsc_pkg::ST_CORRUPTED]);
		$display("%0d incomplete, %0d unmatched closer, %0d overflow; idle and stall up to 53%%",
			status_seen[bsc_pkg::ST_INCOMPLETE], status_seen[bsc_pkg::ST_UNMATCHED],
			status_seen[bsc_pkg::ST_OVERFLOW]);
		if (errors == 0)
			$display("[bracket_syntax_checker] OK");
		else
			$display("[bracket_syntax_checker] ERROR");
		$finish;
	end

endmodule
